// ===== rtl/core/itra_pkg.sv =====
package itra_pkg;

    localparam int VALUE_BITS = 32;
    localparam int RADIX_W    = 6;
    localparam int CHAR_W     = 8;
    localparam int STEP_W     = $clog2(VALUE_BITS);
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int IDX_W      = $clog2(VALUE_BITS);

    localparam logic [RADIX_W-1:0] RADIX_RESET   = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_MIN     = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX     = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_DECIMAL = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] DECIMAL_DIGITS = RADIX_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2d;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic store;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic quo_zero;
        logic cnt_one;
        logic neg_pend;
        logic out_free;
    } t_stat;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W - RADIX_W){1'b0}}, d};
        if (d < DECIMAL_DIGITS) begin
            digit_char = CHAR_ZERO + d_ext;
        end else begin
            digit_char = CHAR_LOWER_A + d_ext - {{(CHAR_W - RADIX_W){1'b0}}, DECIMAL_DIGITS};
        end
    endfunction

endpackage

// ===== rtl/core/itra_ctrl.sv =====
module itra_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  itra_pkg::t_stat i_stat,
    output itra_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_STORE,
        ST_EMIT
    } t_state;

    t_state r_state, n_state;
    logic [itra_pkg::STEP_W-1:0] r_step, n_step;
    logic last_step;
    logic emit_last;

    assign last_step  = (r_step == itra_pkg::STEP_W'(itra_pkg::VALUE_BITS - 1));
    assign o_in_ready = (r_state == ST_IDLE);
    assign emit_last  = !i_stat.neg_pend && i_stat.cnt_one;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (last_step) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                o_cmd.store = 1'b1;
                n_step      = '0;
                n_state     = i_stat.quo_zero ? ST_EMIT : ST_DIV;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    a_load_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_DIV) && (r_step == '0))
        else $error("load did not start a division pass");

    a_store_after_full_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STORE) |-> $past(r_state == ST_DIV) && $past(last_step))
        else $error("digit stored before all division steps ran");

endmodule

// ===== rtl/core/itra_dpath.sv =====
module itra_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [itra_pkg::RADIX_W-1:0]        i_cfg_radix,
    input  logic [itra_pkg::VALUE_BITS-1:0]     i_value,
    input  logic                                i_out_ready,
    input  itra_pkg::t_cmd                      i_cmd,
    output itra_pkg::t_stat                     o_stat,
    output logic                                o_out_valid,
    output logic [itra_pkg::CHAR_W-1:0]         o_text_char,
    output logic                                o_last_char
);

    logic [itra_pkg::RADIX_W-1:0]    r_radix;
    logic [itra_pkg::VALUE_BITS-1:0] r_quo;
    logic [itra_pkg::RADIX_W-1:0]    r_rem;
    logic [itra_pkg::CNT_W-1:0]      r_cnt;
    logic                            r_neg;
    logic                            r_out_valid;
    logic [itra_pkg::CHAR_W-1:0]     r_out_char;
    logic                            r_out_last;
    logic [itra_pkg::CHAR_W-1:0]     r_buf [itra_pkg::VALUE_BITS];

    logic [itra_pkg::RADIX_W-1:0]    base;
    logic [itra_pkg::RADIX_W:0]      rem_sh;
    logic                            rem_ge;
    logic [itra_pkg::RADIX_W:0]      rem_sub;
    logic                            in_neg;
    logic [itra_pkg::VALUE_BITS-1:0] in_mag;
    logic [itra_pkg::CNT_W-1:0]      cnt_dec;

    always_comb begin
        if (r_radix < itra_pkg::RADIX_MIN) begin
            base = itra_pkg::RADIX_MIN;
        end else if (r_radix > itra_pkg::RADIX_MAX) begin
            base = itra_pkg::RADIX_MAX;
        end else begin
            base = r_radix;
        end
    end

    assign in_neg  = (base == itra_pkg::RADIX_DECIMAL) && i_value[itra_pkg::VALUE_BITS-1];
    assign in_mag  = in_neg ? (~i_value + 1'b1) : i_value;

    // one restoring step: shift in the next quotient bit
    assign rem_sh  = {r_rem, r_quo[itra_pkg::VALUE_BITS-1]};
    assign rem_ge  = (rem_sh >= {1'b0, base});
    assign rem_sub = rem_sh - {1'b0, base};
    assign cnt_dec = r_cnt - 1'b1;

    assign o_stat.quo_zero = (r_quo == '0);
    assign o_stat.cnt_one  = (r_cnt == itra_pkg::CNT_W'(1));
    assign o_stat.neg_pend = r_neg;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_text_char = r_out_char;
    assign o_last_char = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix     <= itra_pkg::RADIX_RESET;
            r_cnt       <= '0;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_radix <= i_cfg_radix;
            end
            if (i_cmd.load) begin
                r_quo <= in_mag;
                r_rem <= '0;
                r_cnt <= '0;
                r_neg <= in_neg;
            end
            if (i_cmd.div_step) begin
                r_quo <= {r_quo[itra_pkg::VALUE_BITS-2:0], rem_ge};
                r_rem <= rem_ge ? rem_sub[itra_pkg::RADIX_W-1:0]
                                : rem_sh[itra_pkg::RADIX_W-1:0];
            end
            if (i_cmd.store) begin
                r_buf[r_cnt[itra_pkg::IDX_W-1:0]] <= itra_pkg::digit_char(r_rem);
                r_cnt <= r_cnt + 1'b1;
                r_rem <= '0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (r_neg) begin
                    r_out_char <= itra_pkg::CHAR_MINUS;
                    r_out_last <= 1'b0;
                    r_neg      <= 1'b0;
                end else begin
                    r_out_char <= r_buf[cnt_dec[itra_pkg::IDX_W-1:0]];
                    r_out_last <= (r_cnt == itra_pkg::CNT_W'(1));
                    r_cnt      <= cnt_dec;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= itra_pkg::CNT_W'(itra_pkg::VALUE_BITS))
        else $error("digit count above buffer depth");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && !r_neg && (r_cnt == itra_pkg::CNT_W'(1))) |=>
            (r_cnt == '0) && r_out_last)
        else $error("final character did not drain the digit buffer");

endmodule

// ===== rtl/core/integer_to_radix_ascii_unit.sv =====
// Integer to ASCII text converter. Each input word is one 32-bit two's
// complement integer; the block returns its text in the configured radix
// (2..36, digits 0-9 then a-z), one character per output word, most
// significant first, with o_last_char set on the final character. Zero gives
// a single '0'. In radix ten a negative value is written as '-' and its
// magnitude (the most negative value included); every other radix reads the
// input as unsigned. Radix values below two act as two, above 36 as 36.
// Each digit costs one pass of a shared 1-bit-per-cycle restoring divider
// followed by a store step. One item is in work at a time; o_in_ready is
// high only while the converter is free, and the next item may be taken
// while the final character still sits in the output register. Write the
// radix only while no conversion is in progress.
module integer_to_radix_ascii_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [itra_pkg::RADIX_W-1:0]    i_cfg_radix,
    // input words
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [itra_pkg::VALUE_BITS-1:0] i_value,
    // output words
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [itra_pkg::CHAR_W-1:0]     o_text_char,
    output logic                            o_last_char
);

    itra_pkg::t_cmd  cmd;
    itra_pkg::t_stat stat;

    // radix register takes a write every cycle
    assign o_cfg_ready = 1'b1;

    itra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // divider, digit buffer (filled low digit first, read back in reverse)
    // and the output register
    itra_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_radix (i_cfg_radix),
        .i_value     (i_value),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

endmodule
